FILE: src/bfvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfvg_pkg;

  localparam int UV_FRAC    = 15;
  localparam int QW         = 32;
  localparam int BPS        = 4;
  localparam int DIV_STAGES = QW / BPS;
  localparam int IN_W       = 256;
  localparam int OUT_W      = 328;

  localparam logic [2:0] FACE_MAX = 3'd5;

  // Field order matches tdata: face sits in the lowest bits.
  typedef struct packed {
    logic [15:0] v_second;
    logic [15:0] u_second;
    logic [15:0] v_first;
    logic [15:0] u_first;
    logic [30:0] len_z;
    logic [30:0] len_y;
    logic [30:0] len_x;
    logic [31:0] org_z;
    logic [31:0] org_y;
    logic [31:0] org_x;
    logic [2:0]  face;
  } req_t;

  // One restoring divider lane: quotient of {rem, nlo} by dvs.
  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] nlo;
    logic [15:0] dvs;
    logic [31:0] q;
    logic        ovf;
    logic        neg;
  } lane_t;

  // Corner masks per face, vertex 0 in the lowest three bits.
  function automatic logic [11:0] corners(input logic [2:0] f);
    case (f)
      3'd0:    return {3'd0, 3'd1, 3'd3, 3'd2};
      3'd1:    return {3'd1, 3'd5, 3'd7, 3'd3};
      3'd2:    return {3'd5, 3'd4, 3'd6, 3'd7};
      3'd3:    return {3'd4, 3'd0, 3'd2, 3'd6};
      3'd4:    return {3'd1, 3'd0, 3'd4, 3'd5};
      3'd5:    return {3'd2, 3'd3, 3'd7, 3'd6};
      default: return 12'd0;
    endcase
  endfunction

  function automatic logic [2:0] corner(input logic [2:0] f, input logic [1:0] k);
    logic [11:0] c;
    c = corners(f);
    return c[3*k +: 3];
  endfunction

  // Even faces take u_second on the outer vertices, odd faces on the inner ones.
  function automatic logic usel(input logic [2:0] f, input logic [1:0] k);
    logic outer;
    outer = (k == 2'd0) || (k == 2'd3);
    return f[0] ? !outer : outer;
  endfunction

  function automatic lane_t div_step(input lane_t l);
    lane_t       r;
    logic [16:0] t;
    r = l;
    t = {l.rem, l.nlo[31]};
    if (t >= {1'b0, l.dvs}) begin
      r.rem = 16'(t - {1'b0, l.dvs});
      r.q   = {l.q[30:0], 1'b1};
    end else begin
      r.rem = t[15:0];
      r.q   = {l.q[30:0], 1'b0};
    end
    r.nlo = {l.nlo[30:0], 1'b0};
    return r;
  endfunction

  function automatic logic [31:0] sat(input lane_t l);
    if (l.neg) begin
      if (l.ovf || l.q > 32'h8000_0000) return 32'h8000_0000;
      return 32'(0) - l.q;
    end
    if (l.ovf || l.q[31]) return 32'h7FFF_FFFF;
    return l.q;
  endfunction

endpackage
`default_nettype wire

FILE: src/bfvg_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module bfvg_div_pipe
  import bfvg_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire req_t  req_i,
  input  wire logic  zero_i,
  input  wire lane_t tan_i,
  input  wire lane_t bit_i,
  output logic       valid_o,
  output req_t       req_o,
  output logic       zero_o,
  output lane_t      tan_o,
  output lane_t      bit_o
);

  logic  vld_q  [DIV_STAGES];
  req_t  req_q  [DIV_STAGES];
  logic  zero_q [DIV_STAGES];
  lane_t tan_q  [DIV_STAGES];
  lane_t bit_q  [DIV_STAGES];
  lane_t tan_d  [DIV_STAGES];
  lane_t bit_d  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
    lane_t tan_src, bit_src;
    logic  vld_src, zero_src;
    req_t  req_src;

    if (s == 0) begin : g_first
      assign tan_src  = tan_i;
      assign bit_src  = bit_i;
      assign vld_src  = valid_i;
      assign zero_src = zero_i;
      assign req_src  = req_i;
    end else begin : g_next
      assign tan_src  = tan_q[s-1];
      assign bit_src  = bit_q[s-1];
      assign vld_src  = vld_q[s-1];
      assign zero_src = zero_q[s-1];
      assign req_src  = req_q[s-1];
    end

    // Four quotient bits per stage on each lane.
    always_comb begin
      tan_d[s] = tan_src;
      bit_d[s] = bit_src;
      for (int i = 0; i < BPS; i++) begin
        tan_d[s] = div_step(tan_d[s]);
        bit_d[s] = div_step(bit_d[s]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        req_q[s]  <= req_src;
        zero_q[s] <= zero_src;
        tan_q[s]  <= tan_d[s];
        bit_q[s]  <= bit_d[s];
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign req_o   = req_q[DIV_STAGES-1];
  assign zero_o  = zero_q[DIV_STAGES-1];
  assign tan_o   = tan_q[DIV_STAGES-1];
  assign bit_o   = bit_q[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: src/bfvg_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module bfvg_emit
  import bfvg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire req_t              req_i,
  input  wire logic              zero_i,
  input  wire logic [31:0]       tq_i,
  input  wire logic [31:0]       bq_i,
  output logic                   load_rdy_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output logic [OUT_W-1:0]       m_tdata_o,
  output logic                   m_tlast_o
);

  logic        vld_q, vld_d;
  logic [1:0]  cnt_q, cnt_d;
  req_t        req_q;
  logic        zero_q;
  logic [31:0] tq_q, bq_q;

  logic        load, take;
  logic [2:0]  c, c0, c1, c2, tax, bax;
  logic [31:0] px, py, pz, tx, ty, tz, bx, by, bz;
  logic [15:0] u, v;

  assign take       = vld_q && m_tready_i;
  assign load_rdy_o = !vld_q || (take && cnt_q == 2'd3);
  assign load       = load_rdy_o && valid_i;

  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) vld_d = 1'b0;
    end
    if (load) begin
      vld_d = 1'b1;
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q  <= req_i;
      zero_q <= zero_i;
      tq_q   <= tq_i;
      bq_q   <= bq_i;
    end
  end

  always_comb begin
    c   = corner(req_q.face, cnt_q);
    c0  = corner(req_q.face, 2'd0);
    c1  = corner(req_q.face, 2'd1);
    c2  = corner(req_q.face, 2'd2);
    tax = (c1 ^ c0) & {3{!zero_q}};
    bax = (c2 ^ c1) & {3{!zero_q}};
    px  = req_q.org_x + (c[0] ? {1'b0, req_q.len_x} : 32'd0);
    py  = req_q.org_y + (c[1] ? {1'b0, req_q.len_y} : 32'd0);
    pz  = req_q.org_z + (c[2] ? {1'b0, req_q.len_z} : 32'd0);
    u   = usel(req_q.face, cnt_q) ? req_q.u_second : req_q.u_first;
    v   = cnt_q[1] ? req_q.v_second : req_q.v_first;
    tx  = tax[0] ? tq_q : 32'd0;
    ty  = tax[1] ? tq_q : 32'd0;
    tz  = tax[2] ? tq_q : 32'd0;
    bx  = bax[0] ? bq_q : 32'd0;
    by  = bax[1] ? bq_q : 32'd0;
    bz  = bax[2] ? bq_q : 32'd0;
  end

  assign m_tvalid_o = vld_q;
  assign m_tlast_o  = (cnt_q == 2'd3);
  assign m_tdata_o  = {5'd0, bz, by, bx, tz, ty, tx, u, v, req_q.face, pz, py, px};

endmodule
`default_nettype wire

FILE: src/box_face_vertex_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Signals                 Request / vertex
// s_axis    in         tvalid tready tdata     one face request, 256-bit tdata
// m_axis    out        tvalid tready tdata     one vertex, 328-bit tdata, tlast on vertex 3
//
// A request passes one decode register and eight divider stages (four quotient
// bits each, two lanes), then a vertex register that sends four vertices.
// Reset clears only the valid bits and the vertex counter.
// An output stall holds the decode and divider stages while the last divider stage
// holds a valid request; requests with face code 6 or 7 are dropped.
module box_face_vertex_generator
  import bfvg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // face, org_x, org_y, org_z, len_x, len_y, len_z, u_first, v_first,
  // u_second, v_second
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // pos_x, pos_y, pos_z, normal_code, tex_pair, tan_x, tan_y, tan_z,
  // bitan_x, bitan_y, bitan_z, zero pad
  output logic [OUT_W-1:0]      m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  req_t        req;
  logic        adv, div_vld, div_zero, emit_rdy;
  req_t        div_req;
  lane_t       div_tan, div_bit;

  logic        s0_vld_q;
  req_t        s0_req_q;
  logic        s0_zero_q;
  lane_t       s0_tan_q, s0_bit_q;
  lane_t       tan_d, bit_d;
  logic        zero_d;

  logic [16:0] du, dv;
  logic [15:0] du_mag, dv_mag;
  logic [2:0]  c0, c1, c2, tax, bax;
  logic [30:0] lt, lb;

  assign req = req_t'(s_axis_tdata_i);

  // Both tangent terms reduce to one extent over one UV delta.
  always_comb begin
    du     = req.face[0] ? ({1'b0, req.u_second} - {1'b0, req.u_first})
                         : ({1'b0, req.u_first} - {1'b0, req.u_second});
    dv     = {1'b0, req.v_second} - {1'b0, req.v_first};
    du_mag = du[16] ? 16'(17'(0) - du) : du[15:0];
    dv_mag = dv[16] ? 16'(17'(0) - dv) : dv[15:0];
    zero_d = (du == 17'd0) || (dv == 17'd0);
    c0     = corner(req.face, 2'd0);
    c1     = corner(req.face, 2'd1);
    c2     = corner(req.face, 2'd2);
    tax    = c1 ^ c0;
    bax    = c2 ^ c1;
    lt     = ({31{tax[0]}} & req.len_x) | ({31{tax[1]}} & req.len_y)
           | ({31{tax[2]}} & req.len_z);
    lb     = ({31{bax[0]}} & req.len_x) | ({31{bax[1]}} & req.len_y)
           | ({31{bax[2]}} & req.len_z);
    tan_d.rem = {2'b00, lt[30:17]};
    tan_d.nlo = {lt[16:0], 15'd0};
    tan_d.dvs = du_mag;
    tan_d.q   = 32'd0;
    tan_d.ovf = {2'b00, lt[30:17]} >= du_mag;
    tan_d.neg = ((c1 & tax) == 3'd0) ^ du[16];
    bit_d.rem = {2'b00, lb[30:17]};
    bit_d.nlo = {lb[16:0], 15'd0};
    bit_d.dvs = dv_mag;
    bit_d.q   = 32'd0;
    bit_d.ovf = {2'b00, lb[30:17]} >= dv_mag;
    bit_d.neg = ((c2 & bax) == 3'd0) ^ dv[16];
  end

  assign adv             = !div_vld || emit_rdy;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid_i && (req.face <= FACE_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_req_q  <= req;
      s0_zero_q <= zero_d;
      s0_tan_q  <= tan_d;
      s0_bit_q  <= bit_d;
    end
  end

  bfvg_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s0_vld_q),
    .req_i   (s0_req_q),
    .zero_i  (s0_zero_q),
    .tan_i   (s0_tan_q),
    .bit_i   (s0_bit_q),
    .valid_o (div_vld),
    .req_o   (div_req),
    .zero_o  (div_zero),
    .tan_o   (div_tan),
    .bit_o   (div_bit)
  );

  bfvg_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (div_vld),
    .req_i      (div_req),
    .zero_i     (div_zero),
    .tq_i       (sat(div_tan)),
    .bq_i       (sat(div_bit)),
    .load_rdy_o (emit_rdy),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  a_drop_bad_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (req.face > FACE_MAX) |=> !s0_vld_q)
    else $error("bad face code entered the pipeline");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i && div_vld |-> !s_axis_tready_o)
    else $error("input taken while the pipeline is blocked");

  a_frame_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o
    |=> m_axis_tvalid_o && $stable(m_axis_tdata_o[322:131]))
    else $error("tangent frame changed inside a face");

endmodule
`default_nettype wire
